### rtl/wcag_pkg.sv
// ----------------------------------------------------------------------------
// wcag_pkg
// Shared widths, weights, the sRGB linearization table and the divider
// stage type for the contrast ratio checker.
// ----------------------------------------------------------------------------
package wcag_pkg;

    // Field and fixed-point formats.
    localparam int COMP_W          = 8;
    localparam int LUMA_FRAC_BITS  = 16;
    localparam int RATIO_FRAC_BITS = 8;
    localparam int TABLE_DEPTH     = 1 << COMP_W;

    // Linear value is Q1.LUMA_FRAC_BITS and reaches exactly 1.0 at full code.
    localparam int LIN_W    = LUMA_FRAC_BITS + 1;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = LIN_W + WEIGHT_W;
    // Luminance keeps 16 extra fraction bits from the weights; its maximum is 1.0.
    localparam int Y_FRAC   = LUMA_FRAC_BITS + WEIGHT_W;
    localparam int Y_W      = Y_FRAC + 1;
    // n and d are 20*Y + 1.0, at most 21.0.
    localparam int ND_W     = Y_W + 4;
    // Dividend (n << RATIO_FRAC_BITS) + d/2.
    localparam int NUM_W    = ND_W + RATIO_FRAC_BITS + 1;
    // Quotient never exceeds 21.0 in Q.RATIO_FRAC_BITS, which fits the field.
    localparam int QUOT_W   = 13;
    localparam int REM_W    = ND_W + 1;

    localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
    localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
    localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

    localparam logic [ND_W-1:0]   LUMA_ONE  = ND_W'(1) << Y_FRAC;
    localparam logic [QUOT_W-1:0] RATIO_ONE = QUOT_W'(1) << RATIO_FRAC_BITS;
    localparam logic [QUOT_W-1:0] RATIO_MAX = QUOT_W'(21) << RATIO_FRAC_BITS;

    // Payload of one long-division stage.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ND_W-1:0]   den;
        logic [QUOT_W-1:0] num_lo;
        logic [QUOT_W-1:0] quot;
        logic              aa;
        logic              aaa;
        logic              aa_large;
    } div_data_t;

    typedef logic [LIN_W-1:0] lin_table_t [0:TABLE_DEPTH-1];

    // Unsigned 64-bit quotient by shift and subtract; used only while the
    // constant table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sRGB transfer curve for one code, evaluated at elaboration only.
    // The power segment uses t^2.4 = t^2 * fifth_root(t^2) in Q0.30.
    function automatic logic [LIN_W-1:0] linearize(input int unsigned code);
        logic [63:0] mx;
        logic [63:0] c;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] t;
        logic [63:0] a;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] q30;
        mx  = 64'(TABLE_DEPTH - 1);
        c   = 64'(code) & mx;
        q30 = 64'd1 << 30;
        if (c * 64'd100000 <= 64'd4045 * mx) begin
            den = 64'd1292 * mx;
            v   = udiv64(((c * 64'd100) << LUMA_FRAC_BITS) + (den >> 1), den);
        end else begin
            num = 64'd1000 * c + 64'd55 * mx;
            den = 64'd1055 * mx;
            t   = udiv64((num << 30) + (den >> 1), den);
            if (t > q30) begin
                t = q30;
            end
            a  = (t * t + (q30 >> 1)) >> 30;
            lo = 64'd0;
            hi = q30;
            for (int i = 0; i < 32; i++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    p   = mid;
                    for (int k = 0; k < 4; k++) begin
                        p = (p * mid) >> 30;
                    end
                    if (p <= a) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
            end
            v = (a * lo + (64'd1 << (59 - LUMA_FRAC_BITS))) >> (60 - LUMA_FRAC_BITS);
        end
        return v[LIN_W-1:0];
    endfunction

    function automatic lin_table_t build_lin_table();
        lin_table_t tbl;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl[i] = linearize(i);
        end
        return tbl;
    endfunction

    // Constant ROM of linear component values.
    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

### rtl/wcag_luma.sv
// ----------------------------------------------------------------------------
// wcag_luma
// Three-stage relative luminance unit: table lookup, weighting, sum.
// ----------------------------------------------------------------------------
module wcag_luma (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [wcag_pkg::COMP_W-1:0] red,
    input  logic [wcag_pkg::COMP_W-1:0] green,
    input  logic [wcag_pkg::COMP_W-1:0] blue,
    output logic                       out_valid,
    output logic [wcag_pkg::Y_W-1:0]   luma
);
    import wcag_pkg::*;

    logic [2:0]        valid_reg;
    logic [LIN_W-1:0]  lin_r_reg;
    logic [LIN_W-1:0]  lin_g_reg;
    logic [LIN_W-1:0]  lin_b_reg;
    logic [PROD_W-1:0] prod_r_reg;
    logic [PROD_W-1:0] prod_g_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic [Y_W-1:0]    luma_reg;
    logic [Y_W-1:0]    luma_next;

    // Valid bits follow the data through the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // The weights sum to 1.0, so the total never exceeds 1.0 in Y format.
    assign luma_next = Y_W'({2'b00, prod_r_reg} + {2'b00, prod_g_reg} + {2'b00, prod_b_reg});

    // Lookup, then one multiplier per component, then the sum.
    always_ff @(posedge clk)
    begin
        lin_r_reg  <= LIN_TABLE[red];
        lin_g_reg  <= LIN_TABLE[green];
        lin_b_reg  <= LIN_TABLE[blue];
        prod_r_reg <= PROD_W'(lin_r_reg) * PROD_W'(W_RED);
        prod_g_reg <= PROD_W'(lin_g_reg) * PROD_W'(W_GREEN);
        prod_b_reg <= PROD_W'(lin_b_reg) * PROD_W'(W_BLUE);
        luma_reg   <= luma_next;
    end

    assign out_valid = valid_reg[2];
    assign luma      = luma_reg;

endmodule

### rtl/wcag_div_stage.sv
// ----------------------------------------------------------------------------
// wcag_div_stage
// One restoring long-division step: produces one quotient bit per stage.
// ----------------------------------------------------------------------------
module wcag_div_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  wcag_pkg::div_data_t   in_data,
    output logic                  out_valid,
    output wcag_pkg::div_data_t   out_data
);
    import wcag_pkg::*;

    logic             valid_reg;
    div_data_t        data_reg;
    div_data_t        data_next;
    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] den_ext;
    logic             fits;

    // Bring down the next dividend bit and try the subtraction.
    always_comb
    begin
        rem_shift = {in_data.rem[REM_W-2:0], in_data.num_lo[QUOT_W-1]};
        den_ext   = {1'b0, in_data.den};
        fits      = (rem_shift >= den_ext);
        data_next        = in_data;
        data_next.rem    = fits ? (rem_shift - den_ext) : rem_shift;
        data_next.num_lo = {in_data.num_lo[QUOT_W-2:0], 1'b0};
        data_next.quot   = {in_data.quot[QUOT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/wcag_contrast_ratio_check.sv
// ----------------------------------------------------------------------------
// wcag_contrast_ratio_check
// Contrast ratio of a foreground/background sRGB pair with AA, AAA and
// AA-large pass flags, fully pipelined.
//
//   Channel   Handshake        Payload
//   --------  ---------------  ----------------------------------------------
//   request   start / busy     fg_red, fg_green, fg_blue, bg_red, bg_green,
//                              bg_blue
//   result    done (strobe)    contrast_ratio, meets_aa, meets_aaa,
//                              meets_aa_large
//
// A request is taken on every cycle with start high and busy low; busy is
// high only during reset. Each request passes in order through the
// three luminance stages, one ratio-setup stage, one divider-load stage,
// thirteen divider stages (one quotient bit each) and the output register.
// Reset clears only the valid bits; nothing is in flight afterwards.
// The result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module wcag_contrast_ratio_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [wcag_pkg::COMP_W-1:0]   fg_red,
    input  logic [wcag_pkg::COMP_W-1:0]   fg_green,
    input  logic [wcag_pkg::COMP_W-1:0]   fg_blue,
    input  logic [wcag_pkg::COMP_W-1:0]   bg_red,
    input  logic [wcag_pkg::COMP_W-1:0]   bg_green,
    input  logic [wcag_pkg::COMP_W-1:0]   bg_blue,
    output logic                          done,
    output logic [wcag_pkg::QUOT_W-1:0]   contrast_ratio,
    output logic                          meets_aa,
    output logic                          meets_aaa,
    output logic                          meets_aa_large
);
    import wcag_pkg::*;

    localparam int LATENCY = 3 + 1 + 1 + QUOT_W + 1;

    logic             accept;
    logic             fg_valid;
    logic             bg_valid;
    logic [Y_W-1:0]   fg_luma;
    logic [Y_W-1:0]   bg_luma;

    logic             nd_valid_reg;
    logic [ND_W-1:0]  n_reg;
    logic [ND_W-1:0]  d_reg;
    logic [Y_W-1:0]   hi_luma;
    logic [Y_W-1:0]   lo_luma;
    logic [ND_W-1:0]  n_next;
    logic [ND_W-1:0]  d_next;

    logic [NUM_W-1:0] num_full;
    div_data_t        load_next;
    logic             stage_valid [0:QUOT_W];
    div_data_t        stage_data  [0:QUOT_W];
    logic             load_valid_reg;
    div_data_t        load_reg;

    logic              done_reg;
    logic [QUOT_W-1:0] ratio_reg;
    logic              aa_reg;
    logic              aaa_reg;
    logic              aa_large_reg;

    assign busy   = ~rst_n;
    assign accept = start & ~busy;

    // Luminance of both colors.
    wcag_luma u_fg_luma (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .red       (fg_red),
        .green     (fg_green),
        .blue      (fg_blue),
        .out_valid (fg_valid),
        .luma      (fg_luma)
    );

    wcag_luma u_bg_luma (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .red       (bg_red),
        .green     (bg_green),
        .blue      (bg_blue),
        .out_valid (bg_valid),
        .luma      (bg_luma)
    );

    // Order the two luminances and form n = 20*Yhi + 1, d = 20*Ylo + 1.
    always_comb
    begin
        hi_luma = (fg_luma > bg_luma) ? fg_luma : bg_luma;
        lo_luma = (fg_luma > bg_luma) ? bg_luma : fg_luma;
        n_next  = (ND_W'(hi_luma) << 4) + (ND_W'(hi_luma) << 2) + LUMA_ONE;
        d_next  = (ND_W'(lo_luma) << 4) + (ND_W'(lo_luma) << 2) + LUMA_ONE;
    end

    // Pass flags by cross-multiplied compares, and the rounded dividend.
    always_comb
    begin
        num_full = NUM_W'({n_reg, {RATIO_FRAC_BITS{1'b0}}}) + NUM_W'(d_reg >> 1);
        load_next.rem      = REM_W'(num_full >> QUOT_W);
        load_next.den      = d_reg;
        load_next.num_lo   = num_full[QUOT_W-1:0];
        load_next.quot     = '0;
        load_next.aa       = ((ND_W + 4)'({n_reg, 1'b0}) >=
                              ((ND_W + 4)'(d_reg) << 3) + (ND_W + 4)'(d_reg));
        load_next.aaa      = ((ND_W + 3)'(n_reg) >=
                              ((ND_W + 3)'(d_reg) << 3) - (ND_W + 3)'(d_reg));
        load_next.aa_large = ((ND_W + 2)'(n_reg) >=
                              ((ND_W + 2)'(d_reg) << 1) + (ND_W + 2)'(d_reg));
    end

    // Valid bits of the setup and load stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_valid_reg   <= 1'b0;
            load_valid_reg <= 1'b0;
        end
        else
        begin
            nd_valid_reg   <= fg_valid & bg_valid;
            load_valid_reg <= nd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        load_reg <= load_next;
    end

    assign stage_valid[0] = load_valid_reg;
    assign stage_data[0]  = load_reg;

    // Divider pipeline, one quotient bit per stage.
    genvar gi;
    generate
        for (gi = 0; gi < QUOT_W; gi++)
        begin : g_div
            wcag_div_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (stage_valid[gi]),
                .in_data   (stage_data[gi]),
                .out_valid (stage_valid[gi + 1]),
                .out_data  (stage_data[gi + 1])
            );
        end
    endgenerate

    // Output register; the quotient already fits the field.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        ratio_reg    <= stage_data[QUOT_W].quot;
        aa_reg       <= stage_data[QUOT_W].aa;
        aaa_reg      <= stage_data[QUOT_W].aaa;
        aa_large_reg <= stage_data[QUOT_W].aa_large;
    end

    assign done           = done_reg;
    assign contrast_ratio = ratio_reg;
    assign meets_aa       = aa_reg;
    assign meets_aaa      = aaa_reg;
    assign meets_aa_large = aa_large_reg;

    // Every request comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("request did not produce a result at the pipeline latency");

    // No result strobe appears without a request one latency earlier.
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching request");

    // The ratio stays within 1.0 and 21.0.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (contrast_ratio >= RATIO_ONE && contrast_ratio <= RATIO_MAX))
        else $error("contrast ratio out of range");

    // The flags are nested: AAA implies AA implies AA-large.
    a_nested: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((!meets_aaa || meets_aa) && (!meets_aa || meets_aa_large)))
        else $error("pass flags are not nested");

    // A ratio that rounds to 1.0 passes nothing.
    a_unity: assert property (@(posedge clk) disable iff (!rst_n)
        (done && contrast_ratio == RATIO_ONE) |-> !meets_aa_large)
        else $error("unity ratio reported as passing");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: contrast ratio checker testbench
// Sends foreground/background color requests through the start/busy
// handshake with random idle gaps. Each accepted request is predicted
// in the bench: its own sRGB decode table, luminance and ratio division.
// Every result strobe is checked field by field against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_W   = wcag_pkg::COMP_W;
    localparam int RATIO_W  = wcag_pkg::QUOT_W;
    localparam int LIN_FRAC = wcag_pkg::LUMA_FRAC_BITS;
    localparam int Q_FRAC   = wcag_pkg::RATIO_FRAC_BITS;
    localparam int CODE_MAX = (1 << CODE_W) - 1;

    // Luminance weights in Q16.
    localparam longint unsigned LUMA_WR = 13933;
    localparam longint unsigned LUMA_WG = 46871;
    localparam longint unsigned LUMA_WB = 4732;
    localparam longint unsigned Q30     = 64'd1 << 30;
    localparam longint unsigned RATIO_CAP = (64'd1 << RATIO_W) - 1;

    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [CODE_W-1:0] red;
        logic [CODE_W-1:0] green;
        logic [CODE_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t fg;
        rgb_t bg;
    } color_pair_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               aa;
        logic               aaa;
        logic               aa_large;
    } contrast_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [CODE_W-1:0]  fg_red = '0;
    logic [CODE_W-1:0]  fg_green = '0;
    logic [CODE_W-1:0]  fg_blue = '0;
    logic [CODE_W-1:0]  bg_red = '0;
    logic [CODE_W-1:0]  bg_green = '0;
    logic [CODE_W-1:0]  bg_blue = '0;
    logic               done;
    logic [RATIO_W-1:0] contrast_ratio;
    logic               meets_aa;
    logic               meets_aaa;
    logic               meets_aa_large;

    wcag_contrast_ratio_check dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .fg_red         (fg_red),
        .fg_green       (fg_green),
        .fg_blue        (fg_blue),
        .bg_red         (bg_red),
        .bg_green       (bg_green),
        .bg_blue        (bg_blue),
        .done           (done),
        .contrast_ratio (contrast_ratio),
        .meets_aa       (meets_aa),
        .meets_aaa      (meets_aaa),
        .meets_aa_large (meets_aa_large)
    );

    // Bench-side sRGB decode table in Q1.LIN_FRAC.
    bit [LIN_FRAC:0] srgb_linear [0:CODE_MAX];

    contrast_t expected_contrast [$];
    int unsigned sent_count;
    int unsigned directed_count;
    int unsigned checked_count;
    int unsigned aa_count;
    int unsigned aaa_count;
    int unsigned large_count;
    int unsigned unity_count;
    int unsigned error_count;
    bit          gaps_on = 1'b1;

    // Clock.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // sRGB curve for one code: straight segment near black, otherwise
    // t^2.4 built as t^2 times the fifth root of t^2 in Q0.30.
    function automatic bit [LIN_FRAC:0] srgb_decode(input int unsigned code);
        longint unsigned c;
        longint unsigned full;
        longint unsigned den;
        longint unsigned t;
        longint unsigned sq;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned pw;
        c    = 64'(code);
        full = 64'(CODE_MAX);
        if (c * 100000 <= 4045 * full)
        begin
            den = 1292 * full;
            return (LIN_FRAC + 1)'((((c * 100) << LIN_FRAC) + den / 2) / den);
        end
        den = 1055 * full;
        t   = (((1000 * c + 55 * full) << 30) + den / 2) / den;
        if (t > Q30)
        begin
            t = Q30;
        end
        sq = (t * t + Q30 / 2) >> 30;
        lo = 0;
        hi = Q30;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            pw  = mid;
            repeat (4) pw = (pw * mid) >> 30;
            if (pw <= sq)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return (LIN_FRAC + 1)'((sq * lo + (64'd1 << (59 - LIN_FRAC))) >> (60 - LIN_FRAC));
    endfunction

    // Relative luminance, unrounded, in Q(LIN_FRAC + 16).
    function automatic longint unsigned rel_luma(input rgb_t px);
        return LUMA_WR * srgb_linear[px.red] + LUMA_WG * srgb_linear[px.green]
             + LUMA_WB * srgb_linear[px.blue];
    endfunction

    // Ratio and pass flags of one color pair.
    function automatic contrast_t predict_contrast(input color_pair_t p);
        longint unsigned yf;
        longint unsigned yb;
        longint unsigned unit;
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        contrast_t r;
        yf   = rel_luma(p.fg);
        yb   = rel_luma(p.bg);
        unit = 64'd1 << (LIN_FRAC + 16);
        n    = 20 * ((yf > yb) ? yf : yb) + unit;
        d    = 20 * ((yf > yb) ? yb : yf) + unit;
        q    = ((n << Q_FRAC) + d / 2) / d;
        if (q > RATIO_CAP)
        begin
            q = RATIO_CAP;
        end
        r.ratio    = RATIO_W'(q);
        r.aa       = (2 * n >= 9 * d);
        r.aaa      = (n >= 7 * d);
        r.aa_large = (n >= 3 * d);
        return r;
    endfunction

    // Record a prediction for every request taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_contrast.push_back(predict_contrast(
                {fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue}));
        end
    end

    // Compare every result strobe with the oldest prediction.
    always @(posedge clk)
    begin
        contrast_t want;
        if (done)
        begin
            if (expected_contrast.size() == 0)
            begin
                $error("result with no request outstanding: contrast_ratio %0d",
                       contrast_ratio);
                error_count++;
            end
            else
            begin
                want = expected_contrast.pop_front();
                checked_count++;
                aa_count    += want.aa;
                aaa_count   += want.aaa;
                large_count += want.aa_large;
                unity_count += (want.ratio == (1 << Q_FRAC));
                if (contrast_ratio !== want.ratio)
                begin
                    $error("contrast_ratio: expected %0d, actual %0d",
                           want.ratio, contrast_ratio);
                    error_count++;
                end
                if (meets_aa !== want.aa)
                begin
                    $error("meets_aa: expected %0d, actual %0d", want.aa, meets_aa);
                    error_count++;
                end
                if (meets_aaa !== want.aaa)
                begin
                    $error("meets_aaa: expected %0d, actual %0d", want.aaa, meets_aaa);
                    error_count++;
                end
                if (meets_aa_large !== want.aa_large)
                begin
                    $error("meets_aa_large: expected %0d, actual %0d",
                           want.aa_large, meets_aa_large);
                    error_count++;
                end
            end
        end
    end

    // Idle gap after a request: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!gaps_on)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Hold one request until it is taken, then idle for a random gap.
    task automatic send_request(input color_pair_t p);
        int unsigned gap;
        start    <= 1'b1;
        fg_red   <= p.fg.red;
        fg_green <= p.fg.green;
        fg_blue  <= p.fg.blue;
        bg_red   <= p.bg.red;
        bg_green <= p.bg.green;
        bg_blue  <= p.bg.blue;
        do @(posedge clk); while (busy);
        sent_count++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic rgb_t gray(input int unsigned level);
        return {3{CODE_W'(level)}};
    endfunction

    // Component code, leaning now and then on the ends and the knee of the curve.
    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CODE_W'(CODE_MAX);
            2:       return CODE_W'($urandom_range(9, 12));
            default: return CODE_W'($urandom_range(0, CODE_MAX));
        endcase
    endfunction

    function automatic rgb_t pick_color();
        return {pick_code(), pick_code(), pick_code()};
    endfunction

    // Extremes, primaries, equal colors, the knee of the curve and the
    // neighborhood of the AA threshold.
    task automatic test_directed();
        color_pair_t list [$];
        list.push_back({gray(0), gray(CODE_MAX)});
        list.push_back({gray(CODE_MAX), gray(0)});
        list.push_back({gray(0), gray(0)});
        list.push_back({gray(CODE_MAX), gray(CODE_MAX)});
        list.push_back({gray(128), gray(128)});
        list.push_back({rgb_t'({8'd255, 8'd0, 8'd0}), gray(0)});
        list.push_back({rgb_t'({8'd0, 8'd255, 8'd0}), gray(0)});
        list.push_back({rgb_t'({8'd0, 8'd0, 8'd255}), gray(0)});
        list.push_back({gray(CODE_MAX), rgb_t'({8'd255, 8'd0, 8'd0})});
        list.push_back({gray(CODE_MAX), rgb_t'({8'd0, 8'd255, 8'd0})});
        list.push_back({gray(CODE_MAX), rgb_t'({8'd0, 8'd0, 8'd255})});
        list.push_back({rgb_t'({8'd255, 8'd0, 8'd0}), rgb_t'({8'd0, 8'd255, 8'd255})});
        list.push_back({gray(10), gray(11)});
        list.push_back({gray(10), gray(0)});
        list.push_back({gray(11), gray(0)});
        list.push_back({gray(1), gray(0)});
        list.push_back({gray(254), gray(255)});
        list.push_back({rgb_t'({8'd0, 8'd0, 8'd1}), gray(0)});
        list.push_back({gray(118), gray(CODE_MAX)});
        list.push_back({gray(119), gray(CODE_MAX)});
        list.push_back({gray(CODE_MAX), gray(150)});
        list.push_back({gray(89), gray(0)});
        list.push_back({rgb_t'({8'hAA, 8'h55, 8'hAA}), rgb_t'({8'h55, 8'hAA, 8'h55})});
        foreach (list[i])
        begin
            send_request(list[i]);
        end
        directed_count = list.size();
    endtask

    // Independent random color pairs, bursts alternating with idle gaps.
    task automatic test_random_colors(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
            begin
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            send_request({pick_color(), pick_color()});
        end
    endtask

    // Gray pairs sweep the ratio across every pass threshold, often
    // against pure black or white.
    task automatic test_gray_pairs(input int unsigned count);
        int unsigned a;
        int unsigned b;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            a = $urandom_range(0, CODE_MAX);
            case ($urandom_range(0, 3))
                0:       b = 0;
                1:       b = CODE_MAX;
                default: b = $urandom_range(0, CODE_MAX);
            endcase
            if ($urandom_range(0, 1))
            begin
                send_request({gray(a), gray(b)});
            end
            else
            begin
                send_request({gray(b), gray(a)});
            end
        end
    endtask

    // Nearly equal colors keep the ratio near 1.0, where rounding is tight.
    task automatic test_near_equal(input int unsigned count);
        rgb_t base;
        rgb_t other;
        int   step;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            base  = pick_color();
            other = base;
            for (int k = 0; k < 3; k++)
            begin
                step = int'($urandom_range(0, 4)) - 2;
                if (int'(other[k*CODE_W +: CODE_W]) + step >= 0
                    && int'(other[k*CODE_W +: CODE_W]) + step <= CODE_MAX)
                begin
                    other[k*CODE_W +: CODE_W] = CODE_W'(int'(other[k*CODE_W +: CODE_W]) + step);
                end
            end
            send_request({base, other});
        end
    endtask

    // Main sequence.
    initial
    begin
        int drain;
        for (int i = 0; i <= CODE_MAX; i++)
        begin
            srgb_linear[i] = srgb_decode(i);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_colors(1200);
        test_gray_pairs(450);
        test_near_equal(280);
        start <= 1'b0;

        // Let the pipeline drain, then watch for stray strobes.
        drain = 0;
        while (expected_contrast.size() != 0 && drain < 400)
        begin
            @(posedge clk);
            drain++;
        end
        if (expected_contrast.size() != 0)
        begin
            $error("%0d requests never produced a result", expected_contrast.size());
            error_count++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d directed) and checked %0d results.",
                 sent_count, directed_count, checked_count);
        $display("Passing AA %0d, AAA %0d, AA-large %0d; ratio of exactly 1.0: %0d.",
                 aa_count, aaa_count, large_count, unity_count);
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
